// ===== hdl/wgd_pkg.sv =====
`timescale 1ns / 1ps

package wgd_pkg;

    localparam int COORD_W   = 16;
    localparam int TIME_W    = 32;
    localparam int BAND_W    = 15;
    localparam int COUNT_W   = 8;
    localparam int EVENT_W   = 3;
    localparam int SIDE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_START   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_SWING   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SUCCESS = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd4;
    localparam logic [EVENT_W-1:0] EV_LOST    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_BAND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWINGS_NEEDED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SECONDS = 2'd2;

    localparam logic [BAND_W-1:0]  NEUTRAL_BAND_RESET    = 15'd205;
    localparam logic [COUNT_W-1:0] SWINGS_NEEDED_RESET   = 8'd5;
    localparam logic [COUNT_W-1:0] TIMEOUT_SECONDS_RESET = 8'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] hand_x;
        logic signed [COORD_W-1:0] elbow_x;
        logic signed [COORD_W-1:0] hand_y;
        logic signed [COORD_W-1:0] elbow_y;
        logic [TIME_W-1:0]         now_seconds;
    } frame_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [COUNT_W-1:0] swing_count;
        logic [SIDE_W-1:0]  hand_side;
    } result_t;

endpackage

// ===== hdl/wgd_in_if.sv =====
`timescale 1ns / 1ps

interface wgd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [wgd_pkg::COORD_W-1:0]  hand_x;
    logic signed [wgd_pkg::COORD_W-1:0]  elbow_x;
    logic signed [wgd_pkg::COORD_W-1:0]  hand_y;
    logic signed [wgd_pkg::COORD_W-1:0]  elbow_y;
    logic [wgd_pkg::TIME_W-1:0]          now_seconds;

    modport source (
        output valid, hand_x, elbow_x, hand_y, elbow_y, now_seconds,
        input  ready
    );

    modport sink (
        input  valid, hand_x, elbow_x, hand_y, elbow_y, now_seconds,
        output ready
    );
endinterface

// ===== hdl/wgd_out_if.sv =====
`timescale 1ns / 1ps

interface wgd_out_if;
    logic                          valid;
    logic                          ready;
    logic [wgd_pkg::EVENT_W-1:0]   event_res;
    logic [wgd_pkg::COUNT_W-1:0]   swing_count;
    logic [wgd_pkg::SIDE_W-1:0]    hand_side;

    modport source (
        output valid, event_res, swing_count, hand_side,
        input  ready
    );

    modport sink (
        input  valid, event_res, swing_count, hand_side,
        output ready
    );
endinterface

// ===== hdl/wave_gesture_detector.sv =====
`timescale 1ns / 1ps
// path: the accepted frame passes through the input register, then the result register
// throughput: one item per cycle while the result register is free or being taken; the side, tally
// and start time are registered and feed the very next item, so the state loop sets the rate
// reset: asynchronous active low; clears detection state and pipeline valids,
// and loads the configuration registers with their default values

module wave_gesture_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [wgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wgd_pkg::CFG_DATA_W-1:0]   cfg_data,
    wgd_in_if.sink                           frame,
    wgd_out_if.source                        result
);

    logic [wgd_pkg::BAND_W-1:0]  neutral_band_reg;
    logic [wgd_pkg::COUNT_W-1:0] swings_needed_reg;
    logic [wgd_pkg::COUNT_W-1:0] timeout_seconds_reg;

    logic                        frame_valid_reg;
    wgd_pkg::frame_t             frame_reg;
    logic                        result_valid_reg;
    wgd_pkg::result_t            result_reg;
    wgd_pkg::result_t            result_next;

    logic [wgd_pkg::SIDE_W-1:0]  side_reg;
    logic [wgd_pkg::SIDE_W-1:0]  side_next;
    logic                        in_progress_reg;
    logic                        in_progress_next;
    logic [wgd_pkg::COUNT_W-1:0] tally_reg;
    logic [wgd_pkg::COUNT_W-1:0] tally_next;
    logic [wgd_pkg::TIME_W-1:0]  start_time_reg;
    logic [wgd_pkg::TIME_W-1:0]  start_time_next;

    logic                                 advance;
    logic                                 accept;
    logic signed [wgd_pkg::COORD_W:0]     dx;
    logic signed [wgd_pkg::COORD_W:0]     band_s;
    logic [wgd_pkg::SIDE_W-1:0]           side_now;
    logic                                 lost;
    logic [wgd_pkg::COUNT_W-1:0]          bumped;
    logic [wgd_pkg::TIME_W-1:0]           elapsed;
    logic [wgd_pkg::EVENT_W-1:0]          ev;

    assign advance      = frame_valid_reg && (!result_valid_reg || result.ready);
    assign frame.ready  = !frame_valid_reg || advance;
    assign accept       = frame.valid && frame.ready;

    assign result.valid       = result_valid_reg;
    assign result.event_res   = result_reg.event_res;
    assign result.swing_count = result_reg.swing_count;
    assign result.hand_side   = result_reg.hand_side;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_band_reg    <= wgd_pkg::NEUTRAL_BAND_RESET;
            swings_needed_reg   <= wgd_pkg::SWINGS_NEEDED_RESET;
            timeout_seconds_reg <= wgd_pkg::TIMEOUT_SECONDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                wgd_pkg::CFG_NEUTRAL_BAND:
                    neutral_band_reg <= cfg_data[wgd_pkg::BAND_W-1:0];
                wgd_pkg::CFG_SWINGS_NEEDED:
                    swings_needed_reg <= cfg_data[wgd_pkg::COUNT_W-1:0];
                wgd_pkg::CFG_TIMEOUT_SECONDS:
                    timeout_seconds_reg <= cfg_data[wgd_pkg::COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // classification and state update
    always_comb
    begin
        dx       = {frame_reg.hand_x[wgd_pkg::COORD_W-1], frame_reg.hand_x}
                 - {frame_reg.elbow_x[wgd_pkg::COORD_W-1], frame_reg.elbow_x};
        band_s   = signed'({2'b00, neutral_band_reg});
        if (dx > band_s)
            side_now = wgd_pkg::SIDE_RIGHT;
        else if (dx < -band_s)
            side_now = wgd_pkg::SIDE_LEFT;
        else
            side_now = wgd_pkg::SIDE_NONE;

        lost    = !(frame_reg.hand_y > frame_reg.elbow_y) && in_progress_reg;
        bumped  = (tally_reg == wgd_pkg::COUNT_MAX) ? wgd_pkg::COUNT_MAX
                                                     : tally_reg + 1'b1;
        elapsed = frame_reg.now_seconds - start_time_reg;

        side_next        = side_reg;
        in_progress_next = in_progress_reg;
        tally_next       = tally_reg;
        start_time_next  = start_time_reg;
        ev               = wgd_pkg::EV_NONE;

        if (lost)
        begin
            ev = wgd_pkg::EV_LOST;
        end
        else if (side_now != wgd_pkg::SIDE_NONE)
        begin
            if (side_reg == wgd_pkg::SIDE_NONE)
            begin
                tally_next       = bumped;
                side_next        = side_now;
                in_progress_next = 1'b1;
                start_time_next  = frame_reg.now_seconds;
                ev               = wgd_pkg::EV_START;
            end
            else if (side_now != side_reg)
            begin
                tally_next = bumped;
                side_next  = side_now;
                if (bumped >= swings_needed_reg)
                    ev = wgd_pkg::EV_SUCCESS;
                else if (elapsed > {{(wgd_pkg::TIME_W-wgd_pkg::COUNT_W){1'b0}},
                                    timeout_seconds_reg})
                    ev = wgd_pkg::EV_TIMEOUT;
                else
                    ev = wgd_pkg::EV_SWING;
            end
        end

        result_next.event_res   = ev;
        result_next.swing_count = lost ? '0 : tally_next;
        result_next.hand_side   = lost ? wgd_pkg::SIDE_NONE : side_next;

        // success, timeout and lost tracking end the detection
        if (lost || ev == wgd_pkg::EV_SUCCESS || ev == wgd_pkg::EV_TIMEOUT)
        begin
            side_next        = wgd_pkg::SIDE_NONE;
            in_progress_next = 1'b0;
            tally_next       = '0;
            start_time_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            side_reg         <= wgd_pkg::SIDE_NONE;
            in_progress_reg  <= 1'b0;
            tally_reg        <= '0;
            start_time_reg   <= '0;
        end
        else
        begin
            if (frame.ready)
                frame_valid_reg <= frame.valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result.ready)
                result_valid_reg <= 1'b0;
            if (advance)
            begin
                side_reg        <= side_next;
                in_progress_reg <= in_progress_next;
                tally_reg       <= tally_next;
                start_time_reg  <= start_time_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg.hand_x      <= frame.hand_x;
            frame_reg.elbow_x     <= frame.elbow_x;
            frame_reg.hand_y      <= frame.hand_y;
            frame_reg.elbow_y     <= frame.elbow_y;
            frame_reg.now_seconds <= frame.now_seconds;
        end
        if (advance)
            result_reg <= result_next;
    end

    a_progress_matches_side: assert property (@(posedge clk) disable iff (!rst_n)
        in_progress_reg == (side_reg != wgd_pkg::SIDE_NONE))
        else $error("in_progress out of step with remembered side");

    a_idle_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_progress_reg |-> (tally_reg == '0 && start_time_reg == '0))
        else $error("state not cleared while idle");

    a_lost_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.event_res == wgd_pkg::EV_LOST)
        |-> (result_reg.swing_count == '0 && result_reg.hand_side == wgd_pkg::SIDE_NONE))
        else $error("lost tracking result carries stale values");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid_reg && !advance) |-> !frame.ready)
        else $error("input register would be overwritten");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (result_next.event_res == wgd_pkg::EV_SUCCESS
                     || result_next.event_res == wgd_pkg::EV_TIMEOUT))
        |=> !in_progress_reg)
        else $error("detection not cleared after success or timeout");

endmodule

// ===== verif/wave_gesture_detector_tb.sv =====
`timescale 1ns / 1ps

module wave_gesture_detector_tb;
    import wgd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 250;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        frame_t  f;
        bit      typed;
        result_t r;
    } frame_row_t;

    typedef struct {
        int band;
        int need;
        int tmo;
        int in_idle;
        int out_idle;
        bit hold;
    } setting_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wgd_in_if  frame_bus ();
    wgd_out_if result_bus ();

    wave_gesture_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_bus),
        .result    (result_bus)
    );

    always #2 clk = ~clk;

    // gesture tracking state and register copies
    logic [BAND_W-1:0]  band_reg;
    logic [COUNT_W-1:0] needed_reg;
    logic [COUNT_W-1:0] timeout_reg;
    logic [SIDE_W-1:0]  side_mem;
    bit                 tracking;
    logic [COUNT_W-1:0] tally;
    logic [TIME_W-1:0]  first_swing_time;

    result_t expected_results[$];
    int mismatches = 0;
    int frames_sent = 0;
    int results_checked = 0;
    int settings_used = 1;
    int ev_seen[8];
    int cycle_count = 0;

    int in_idle_pct = 10;
    int out_idle_pct = 10;
    bit hold_request = 1'b0;

    logic [TIME_W-1:0] wave_clock;
    logic [SIDE_W-1:0] wave_side;

    function automatic void clear_tracking();
        side_mem = SIDE_NONE;
        tracking = 1'b0;
        tally = '0;
        first_swing_time = '0;
    endfunction

    function automatic result_t predict_gesture(frame_t f);
        result_t r;
        logic [SIDE_W-1:0]  s;
        logic [EVENT_W-1:0] ev;
        logic [TIME_W-1:0]  elapsed;
        int d;
        ev = EV_NONE;
        if (!($signed(f.hand_y) > $signed(f.elbow_y)) && tracking)
        begin
            clear_tracking();
            r.event_res = EV_LOST;
            r.swing_count = '0;
            r.hand_side = SIDE_NONE;
            return r;
        end
        d = int'($signed(f.hand_x)) - int'($signed(f.elbow_x));
        if (d > int'(band_reg))
            s = SIDE_RIGHT;
        else if (d < -int'(band_reg))
            s = SIDE_LEFT;
        else
            s = SIDE_NONE;
        if (s != SIDE_NONE)
        begin
            if (side_mem == SIDE_NONE)
            begin
                if (tally != COUNT_MAX)
                    tally = tally + 1'b1;
                side_mem = s;
                tracking = 1'b1;
                first_swing_time = f.now_seconds;
                ev = EV_START;
            end
            else if (s != side_mem)
            begin
                if (tally != COUNT_MAX)
                    tally = tally + 1'b1;
                side_mem = s;
                elapsed = f.now_seconds - first_swing_time;
                if (tally >= needed_reg)
                    ev = EV_SUCCESS;
                else if (elapsed > TIME_W'(timeout_reg))
                    ev = EV_TIMEOUT;
                else
                    ev = EV_SWING;
            end
        end
        r.event_res = ev;
        r.swing_count = tally;
        r.hand_side = side_mem;
        if (ev == EV_SUCCESS || ev == EV_TIMEOUT)
            clear_tracking();
        return r;
    endfunction

    function automatic frame_row_t row(int hx, int ex, int hy, int ey, logic [TIME_W-1:0] t,
                                       bit typed, logic [EVENT_W-1:0] ev, int cnt,
                                       logic [SIDE_W-1:0] s);
        frame_row_t w;
        w.f.hand_x = hx[COORD_W-1:0];
        w.f.elbow_x = ex[COORD_W-1:0];
        w.f.hand_y = hy[COORD_W-1:0];
        w.f.elbow_y = ey[COORD_W-1:0];
        w.f.now_seconds = t;
        w.typed = typed;
        w.r.event_res = ev;
        w.r.swing_count = cnt[COUNT_W-1:0];
        w.r.hand_side = s;
        return w;
    endfunction

    // place hand and elbow x so that hand_x - elbow_x equals d without overflow
    function automatic frame_t set_dx(frame_t f, int d);
        int ex;
        int hx;
        if (d >= 0)
            ex = -32768 + int'($urandom_range(65535 - d));
        else
            ex = -32768 - d + int'($urandom_range(65535 + d));
        hx = ex + d;
        f.hand_x = hx[COORD_W-1:0];
        f.elbow_x = ex[COORD_W-1:0];
        return f;
    endfunction

    function automatic frame_t raise_hand(frame_t f);
        int ey;
        int hy;
        ey = -32768 + int'($urandom_range(65534));
        hy = ey + 1 + int'($urandom_range(32766 - ey));
        f.hand_y = hy[COORD_W-1:0];
        f.elbow_y = ey[COORD_W-1:0];
        return f;
    endfunction

    function automatic frame_t lower_hand(frame_t f);
        int ey;
        int hy;
        ey = -32768 + int'($urandom_range(65535));
        hy = -32768 + int'($urandom_range(ey + 32768));
        f.hand_y = hy[COORD_W-1:0];
        f.elbow_y = ey[COORD_W-1:0];
        return f;
    endfunction

    function automatic int side_offset(logic [SIDE_W-1:0] s);
        int b;
        int r;
        b = int'(band_reg);
        r = $urandom_range(1) ? int'($urandom_range(3)) : int'($urandom_range(65534 - b));
        return (s == SIDE_RIGHT) ? b + 1 + r : -(b + 1 + r);
    endfunction

    function automatic int neutral_offset();
        int b;
        b = int'(band_reg);
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? b : -b;
        return -b + int'($urandom_range(2 * b));
    endfunction

    task automatic push_frame(frame_t f, bit typed, result_t typed_r);
        result_t r;
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            @(negedge clk);
        end
        frame_bus.valid <= 1'b1;
        frame_bus.hand_x <= f.hand_x;
        frame_bus.elbow_x <= f.elbow_x;
        frame_bus.hand_y <= f.hand_y;
        frame_bus.elbow_y <= f.elbow_y;
        frame_bus.now_seconds <= f.now_seconds;
        @(posedge clk);
        while (!frame_bus.ready)
            @(posedge clk);
        r = predict_gesture(f);
        expected_results.push_back(typed ? typed_r : r);
        frames_sent++;
    endtask

    // mostly alternating waves with the hand raised, plus repeats, neutral, drops and noise
    task automatic send_random_frame();
        frame_t f;
        int pick;
        pick = $urandom_range(99);
        f = '0;
        wave_clock += ($urandom_range(99) < 4) ? $urandom : $urandom_range(3);
        f.now_seconds = wave_clock;
        if (pick < 55)
        begin
            wave_side = (wave_side == SIDE_LEFT) ? SIDE_RIGHT : SIDE_LEFT;
            f = set_dx(raise_hand(f), side_offset(wave_side));
        end
        else if (pick < 67)
        begin
            if (wave_side == SIDE_NONE)
                wave_side = SIDE_LEFT;
            f = set_dx(raise_hand(f), side_offset(wave_side));
        end
        else if (pick < 79)
            f = set_dx(raise_hand(f), neutral_offset());
        else if (pick < 86)
            f = set_dx(lower_hand(f), $urandom_range(1) ? side_offset(wave_side)
                                                         : neutral_offset());
        else
            f = frame_t'({$urandom, $urandom, $urandom});
        push_frame(f, 1'b0, '0);
    endtask

    task automatic settle();
        @(negedge clk);
        frame_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_registers(int band, int need, int tmo);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NEUTRAL_BAND;
        cfg_data <= band[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_SWINGS_NEEDED;
        cfg_data <= {7'($urandom), need[COUNT_W-1:0]};
        @(negedge clk);
        cfg_index <= CFG_TIMEOUT_SECONDS;
        cfg_data <= {7'($urandom), tmo[COUNT_W-1:0]};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        band_reg = band[BAND_W-1:0];
        needed_reg = need[COUNT_W-1:0];
        timeout_reg = tmo[COUNT_W-1:0];
    endtask

    task automatic report(string field, int want, int got);
        mismatches++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.event_res = result_bus.event_res;
            got.swing_count = result_bus.swing_count;
            got.hand_side = result_bus.hand_side;
            ev_seen[got.event_res]++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with nothing expected, got event %0d count %0d side %0d",
                         $time, got.event_res, got.swing_count, got.hand_side);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.event_res !== want.event_res)
                    report("event_res", want.event_res, got.event_res);
                if (got.swing_count !== want.swing_count)
                    report("swing_count", want.swing_count, got.swing_count);
                if (got.hand_side !== want.hand_side)
                    report("hand_side", want.hand_side, got.hand_side);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        frame_row_t rows[$];
        setting_t   settings[$];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        frame_bus.valid = 1'b0;
        frame_bus.hand_x = '0;
        frame_bus.elbow_x = '0;
        frame_bus.hand_y = '0;
        frame_bus.elbow_y = '0;
        frame_bus.now_seconds = '0;
        band_reg = NEUTRAL_BAND_RESET;
        needed_reg = SWINGS_NEEDED_RESET;
        timeout_reg = TIMEOUT_SECONDS_RESET;
        clear_tracking();
        wave_side = SIDE_NONE;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: band 205, five swings, five seconds
        rows = '{
            row(205, 0, 100, 0, 0, 1, EV_NONE, 0, SIDE_NONE),
            row(-205, 0, 100, 0, 1, 1, EV_NONE, 0, SIDE_NONE),
            row(-32768, 32767, 0, 0, 10, 1, EV_START, 1, SIDE_LEFT),
            row(-206, 0, 100, 0, 10, 1, EV_NONE, 1, SIDE_LEFT),
            row(32767, -32768, 32767, -32768, 11, 1, EV_SWING, 2, SIDE_RIGHT),
            row(-206, 0, 100, 0, 12, 0, EV_NONE, 0, SIDE_NONE),
            row(206, 0, 100, 0, 13, 0, EV_NONE, 0, SIDE_NONE),
            row(-300, 0, 100, 0, 14, 1, EV_SUCCESS, 5, SIDE_LEFT),
            row(300, 0, 100, 0, 20, 1, EV_START, 1, SIDE_RIGHT),
            row(-300, 0, 100, 0, 26, 1, EV_TIMEOUT, 2, SIDE_LEFT),
            row(-300, 0, 100, 0, 30, 1, EV_START, 1, SIDE_LEFT),
            row(300, 0, 100, 0, 35, 0, EV_NONE, 0, SIDE_NONE),
            row(300, 0, 0, 0, 36, 1, EV_LOST, 0, SIDE_NONE),
            row(300, 0, 100, 0, 32'hFFFF_FFFF, 1, EV_START, 1, SIDE_RIGHT),
            row(-300, 0, 100, 0, 4, 0, EV_NONE, 0, SIDE_NONE),
            row(300, 0, 100, 0, 5, 1, EV_TIMEOUT, 3, SIDE_RIGHT),
            row(0, 0, -32768, 32767, 6, 1, EV_NONE, 0, SIDE_NONE),
            row(-300, 0, 100, 0, 100, 1, EV_START, 1, SIDE_LEFT),
            row(-300, 0, -1, 0, 101, 1, EV_LOST, 0, SIDE_NONE),
            row(32767, 32767, 100, 0, 102, 1, EV_NONE, 0, SIDE_NONE)
        };
        foreach (rows[i])
            push_frame(rows[i].f, rows[i].typed, rows[i].r);

        settings = '{
            '{205, 5, 5, 10, 10, 1'b0},
            '{0, 1, 0, 10, 10, 1'b0},
            '{32767, 255, 255, 10, 10, 1'b0},
            '{100, 0, 3, 0, 0, 1'b1},
            '{1000, 2, 255, 10, 10, 1'b0},
            '{50, 255, 0, 10, 10, 1'b0},
            '{3000, 8, 10, 10, 10, 1'b0},
            '{205, 5, 5, 10, 10, 1'b0}
        };
        foreach (settings[k])
        begin
            settle();
            in_idle_pct = settings[k].in_idle;
            out_idle_pct = settings[k].out_idle;
            write_registers(settings[k].band, settings[k].need, settings[k].tmo);
            settings_used++;
            if (settings[k].hold)
                hold_request = 1'b1;
            wave_clock = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF - $urandom_range(30)
                                                  : $urandom;
            repeat (PHASE_ITEMS) send_random_frame();
        end
        settle();

        $display("checked %0d results from %0d frames under %0d register settings",
                 results_checked, frames_sent, settings_used);
        $display("events seen: none %0d, started %0d, swing %0d, success %0d, timeout %0d, lost %0d",
                 ev_seen[EV_NONE], ev_seen[EV_START], ev_seen[EV_SWING],
                 ev_seen[EV_SUCCESS], ev_seen[EV_TIMEOUT], ev_seen[EV_LOST]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/wgd_pkg.sv
hdl/wgd_in_if.sv
hdl/wgd_out_if.sv
hdl/wave_gesture_detector.sv
verif/wave_gesture_detector_tb.sv
